// ===== hw/rtl/ssm_pkg.sv =====
// Shared types, field widths and codes for the scrolling segment marquee.
package ssm_pkg;

    // Default geometry of the display and the message store.
    localparam int DIGITS_DEF       = 4;
    localparam int MAX_MESSAGES_DEF = 8;
    localparam int MAX_LENGTH_DEF   = 32;

    // Input item field widths.
    localparam int ACTION_W = 2;
    localparam int SEL_W    = 3;
    localparam int CPOS_W   = 5;
    localparam int GLYPH_W  = 8;
    localparam int LEN_W    = 6;

    // Input stream packing: tuser carries the action, tdata the rest.
    localparam int IN_TUSER_W = ACTION_W;
    localparam int IN_BITS    = SEL_W + CPOS_W + GLYPH_W + LEN_W;
    localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;

    // Action codes.
    localparam logic [ACTION_W-1:0] ACT_TICK   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_GLYPH  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_LENGTH = 2'd2;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int COUNT_W    = 4;
    localparam int PERIOD_W   = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MESSAGE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_PERIOD = 2'd1;

    localparam logic [COUNT_W-1:0]  COUNT_RESET  = 4'd7;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd666;

    // Depth of the result queue between the front and back parts.
    localparam int QUEUE_DEPTH = 4;

    // Control handed from the front part to the back part for one refresh tick.
    typedef struct packed {
        logic valid;
        logic blank;
    } t_tick_req;

endpackage : ssm_pkg

// ===== hw/rtl/ssm_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module ssm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule : ssm_ram

// ===== hw/rtl/ssm_front.sv =====
// Front part: accepts items, performs loads, and advances the scroll state per tick.
module ssm_front #(
    parameter int DIGITS       = 4,
    parameter int MAX_MESSAGES = 8,
    parameter int MAX_LENGTH   = 32,
    localparam int MSG_W  = (MAX_MESSAGES > 1) ? $clog2(MAX_MESSAGES) : 1,
    localparam int POS_W  = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1,
    localparam int DIG_W  = (DIGITS > 1) ? $clog2(DIGITS) : 1,
    localparam int ADDR_W = MSG_W + POS_W
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Item stream
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [ssm_pkg::IN_TDATA_W-1:0]   i_s_tdata,  // sel, char_position, glyph, length
    input  logic [ssm_pkg::IN_TUSER_W-1:0]   i_s_tuser,  // action
    // Configuration writes
    input  logic                             i_cfg_valid,
    input  logic [ssm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ssm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // Space in the back part for one more tick
    input  logic                             i_credit,
    // Glyph store access
    output logic                             o_ram_we,
    output logic [ADDR_W-1:0]                o_ram_waddr,
    output logic [ssm_pkg::GLYPH_W-1:0]      o_ram_wdata,
    output logic                             o_ram_re,
    output logic [ADDR_W-1:0]                o_ram_raddr,
    // Tick request toward the back part
    output ssm_pkg::t_tick_req               o_req,
    output logic [DIG_W-1:0]                 o_req_digit
);

    import ssm_pkg::*;

    localparam int SP_W  = $clog2(MAX_LENGTH + DIGITS) + 1;
    localparam int EFF_W = COUNT_W + 1;
    localparam logic signed [SP_W-1:0] POS_START = SP_W'(1 - DIGITS);

    // Unpacked item fields.
    logic [ACTION_W-1:0] action;
    logic [SEL_W-1:0]    sel;
    logic [CPOS_W-1:0]   cpos;
    logic [GLYPH_W-1:0]  glyph;
    logic [LEN_W-1:0]    len_in;

    assign action = i_s_tuser;
    assign sel    = i_s_tdata[SEL_W-1:0];
    assign cpos   = i_s_tdata[SEL_W +: CPOS_W];
    assign glyph  = i_s_tdata[SEL_W+CPOS_W +: GLYPH_W];
    assign len_in = i_s_tdata[SEL_W+CPOS_W+GLYPH_W +: LEN_W];

    // State registers.
    logic [LEN_W-1:0]       r_len_tab [MAX_MESSAGES];
    logic [MSG_W-1:0]       r_cur;
    logic [LEN_W-1:0]       r_cur_len;
    logic signed [SP_W-1:0] r_pos;
    logic [PERIOD_W-1:0]    r_tick;
    logic [DIG_W-1:0]       r_dig;
    logic [COUNT_W-1:0]     r_count;
    logic [PERIOD_W-1:0]    r_period;

    logic accept, tick_acc, glyph_acc, len_acc;
    logic sel_ok, cpos_ok;
    logic [MSG_W-1:0] sel_idx;
    logic [LEN_W-1:0] len_clip;

    assign o_s_tready = i_credit;
    assign accept     = i_s_tvalid && i_credit;
    assign sel_ok     = int'(sel) < MAX_MESSAGES;
    assign cpos_ok    = int'(cpos) < MAX_LENGTH;
    assign sel_idx    = MSG_W'(sel);
    assign tick_acc   = accept && (action == ACT_TICK);
    assign glyph_acc  = accept && (action == ACT_GLYPH) && sel_ok && cpos_ok;
    assign len_acc    = accept && (action == ACT_LENGTH) && sel_ok;
    assign len_clip   = (int'(len_in) > MAX_LENGTH) ? LEN_W'(MAX_LENGTH) : len_in;

    // Next message with wrap at the effective message count.
    logic [EFF_W-1:0] eff_cnt;
    logic [MSG_W:0]   cur_inc;
    logic [MSG_W-1:0] nxt;

    always_comb begin
        if (r_count == '0) begin
            eff_cnt = EFF_W'(1);
        end else if (int'(r_count) > MAX_MESSAGES) begin
            eff_cnt = EFF_W'(MAX_MESSAGES);
        end else begin
            eff_cnt = EFF_W'(r_count);
        end
    end

    assign cur_inc = {1'b0, r_cur} + (MSG_W + 1)'(1);
    assign nxt     = (EFF_W'(cur_inc) >= eff_cnt) ? '0 : cur_inc[MSG_W-1:0];

    // Rewind decision and the glyph position under the active digit.
    logic                   rewind;
    logic signed [SP_W-1:0] pos_eff;
    logic signed [SP_W-1:0] at;
    logic signed [SP_W-1:0] len_eff_s;
    logic [LEN_W-1:0]       len_eff;
    logic [MSG_W-1:0]       cur_eff;
    logic                   visible;

    assign rewind    = r_pos >= $signed(SP_W'(r_cur_len));
    assign pos_eff   = rewind ? POS_START : r_pos;
    assign len_eff   = rewind ? r_len_tab[nxt] : r_cur_len;
    assign cur_eff   = rewind ? nxt : r_cur;
    assign len_eff_s = $signed(SP_W'(len_eff));
    assign at        = pos_eff + $signed(SP_W'(r_dig));
    assign visible   = !at[SP_W-1] && (at < len_eff_s);

    // Glyph store ports.
    assign o_ram_we    = glyph_acc;
    assign o_ram_waddr = {sel_idx, POS_W'(cpos)};
    assign o_ram_wdata = glyph;
    assign o_ram_re    = tick_acc;
    assign o_ram_raddr = {cur_eff, POS_W'(at)};

    // Tick request to the back part.
    assign o_req.valid = tick_acc;
    assign o_req.blank = !visible;
    assign o_req_digit = r_dig;

    // Length table.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_MESSAGES; i++) begin
                r_len_tab[i] <= '0;
            end
        end else if (len_acc) begin
            r_len_tab[sel_idx] <= len_clip;
        end
    end

    // Scroll state, updated once per refresh tick; the current length shadow also follows length loads.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur     <= '0;
            r_cur_len <= '0;
            r_pos     <= POS_START;
            r_tick    <= '0;
            r_dig     <= '0;
        end else if (tick_acc) begin
            r_cur     <= cur_eff;
            r_cur_len <= len_eff;
            if (r_tick >= r_period) begin
                r_pos  <= pos_eff + SP_W'(1);
                r_tick <= PERIOD_W'(1);
            end else begin
                r_pos  <= pos_eff;
                r_tick <= r_tick + PERIOD_W'(1);
            end
            if (int'(r_dig) == DIGITS - 1) begin
                r_dig <= '0;
            end else begin
                r_dig <= r_dig + DIG_W'(1);
            end
        end else if (len_acc && (sel_idx == r_cur)) begin
            // Keep the shadow of the current message's length coherent.
            r_cur_len <= len_clip;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= COUNT_RESET;
            r_period <= PERIOD_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MESSAGE_COUNT: r_count  <= i_cfg_data[COUNT_W-1:0];
                CFG_SCROLL_PERIOD: r_period <= i_cfg_data[PERIOD_W-1:0];
                default: ;
            endcase
        end
    end

endmodule : ssm_front

// ===== hw/rtl/ssm_back.sv =====
// Back part: forms the digit drive from the glyph read and queues it for output.
module ssm_back #(
    parameter int DIGITS = 4,
    localparam int DIG_W       = (DIGITS > 1) ? $clog2(DIGITS) : 1,
    localparam int OUT_BITS    = ssm_pkg::GLYPH_W + DIGITS + DIG_W,
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ssm_pkg::t_tick_req           i_req,
    input  logic [DIG_W-1:0]             i_req_digit,
    input  logic [ssm_pkg::GLYPH_W-1:0]  i_rdata,
    output logic                         o_credit,
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    output logic [OUT_TDATA_W-1:0]       o_m_tdata   // segments, digit_select_n, digit_number
);

    import ssm_pkg::*;

    localparam int QP_W = $clog2(QUEUE_DEPTH);
    localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

    // Tick waiting for its glyph read to return.
    t_tick_req        r_pend;
    logic [DIG_W-1:0] r_pend_dig;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_dig <= i_req_digit;
    end

    // Result entry assembled from the returned glyph.
    logic [GLYPH_W-1:0]  seg;
    logic [DIGITS-1:0]   dsel_n;
    logic [OUT_BITS-1:0] entry;

    assign seg    = r_pend.blank ? '0 : i_rdata;
    assign dsel_n = ~(DIGITS'(1) << r_pend_dig);
    assign entry  = {r_pend_dig, dsel_n, seg};

    // Result queue.
    logic [OUT_BITS-1:0] r_q [QUEUE_DEPTH];
    logic [QP_W-1:0]     r_wr, r_rd;
    logic [QC_W-1:0]     r_occ;
    logic                push, pop;
    logic [QC_W-1:0]     used;

    assign push = r_pend.valid;
    assign pop  = o_m_tvalid && i_m_tready;
    assign used = r_occ + QC_W'(r_pend.valid);

    // Credit counts the queue and the tick in flight, so a stalled output never drops one.
    assign o_credit   = int'(used) < QUEUE_DEPTH;
    assign o_m_tvalid = r_occ != '0;
    assign o_m_tdata  = OUT_TDATA_W'(r_q[r_rd]);

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_occ <= '0;
        end else begin
            if (push) begin
                r_wr <= (int'(r_wr) == QUEUE_DEPTH - 1) ? '0 : r_wr + QP_W'(1);
            end
            if (pop) begin
                r_rd <= (int'(r_rd) == QUEUE_DEPTH - 1) ? '0 : r_rd + QP_W'(1);
            end
            if (push && !pop) begin
                r_occ <= r_occ + QC_W'(1);
            end else if (pop && !push) begin
                r_occ <= r_occ - QC_W'(1);
            end
        end
    end

endmodule : ssm_back

// ===== hw/rtl/scrolling_segment_marquee.sv =====
// Scrolling seven-segment marquee: item acceptance, glyph store and result queue.
// A tick's glyph read and request are registered, then its entry enters the result queue.
// One item per cycle unless stalled; the glyph store serves one load or one tick read per cycle.
// Loads give no result; the input stalls while the queue and the tick in flight fill four entries.
// Reset is synchronous, active low: lengths, scroll state and registers return to defaults.
// The glyph store is not cleared; the user must read an entry only after it was written (unenforced).
module scrolling_segment_marquee #(
    parameter int DIGITS       = ssm_pkg::DIGITS_DEF,
    parameter int MAX_MESSAGES = ssm_pkg::MAX_MESSAGES_DEF,
    parameter int MAX_LENGTH   = ssm_pkg::MAX_LENGTH_DEF,
    localparam int DIG_W       = (DIGITS > 1) ? $clog2(DIGITS) : 1,
    localparam int OUT_BITS    = ssm_pkg::GLYPH_W + DIGITS + DIG_W,
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Item stream
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [ssm_pkg::IN_TDATA_W-1:0] i_s_tdata,  // message_select, char_position,
                                                        // glyph_bits, message_length
    input  logic [ssm_pkg::IN_TUSER_W-1:0] i_s_tuser,  // action
    // Result stream
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [OUT_TDATA_W-1:0]         o_m_tdata,  // segments, digit_select_n, digit_number
    // Configuration writes
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ssm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ssm_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    import ssm_pkg::*;

    localparam int MSG_W  = (MAX_MESSAGES > 1) ? $clog2(MAX_MESSAGES) : 1;
    localparam int POS_W  = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
    localparam int ADDR_W = MSG_W + POS_W;

    logic                credit;
    logic                ram_we, ram_re;
    logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
    logic [GLYPH_W-1:0]  ram_wdata, ram_rdata;
    t_tick_req           req;
    logic [DIG_W-1:0]    req_digit;

    // Registers are always writable.
    assign o_cfg_ready = 1'b1;

    // Front part: loads and scroll state.
    ssm_front #(
        .DIGITS       (DIGITS),
        .MAX_MESSAGES (MAX_MESSAGES),
        .MAX_LENGTH   (MAX_LENGTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_credit    (credit),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .o_req       (req),
        .o_req_digit (req_digit)
    );

    // Glyph store.
    ssm_ram #(
        .WIDTH (GLYPH_W),
        .DEPTH (2 ** ADDR_W)
    ) u_glyph_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Back part: digit drive and result queue.
    ssm_back #(
        .DIGITS (DIGITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req),
        .i_req_digit (req_digit),
        .i_rdata     (ram_rdata),
        .o_credit    (credit),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

endmodule : scrolling_segment_marquee
